[sv/ghp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle pool package
// Shared sizes, operation codes, controller states and command types.
// ----------------------------------------------------------------------------
package ghp_pkg;

   // Table size and field widths.
   localparam int SLOTS  = 256;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int GEN_W  = 16;
   localparam int DATA_W = 32;
   localparam int OP_W   = 2;

   // Free-slot search is split into groups of slots.
   localparam int LOW_BITS   = IDX_W / 2;
   localparam int GRP_BITS   = IDX_W - LOW_BITS;
   localparam int GROUP_SIZE = 1 << LOW_BITS;
   localparam int GROUPS     = 1 << GRP_BITS;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_GET    = 2'd0;
   localparam logic [OP_W-1:0] OP_CREATE = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic read;
      logic exec;
   } cmd_type;

endpackage

[sv/ghp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle pool controller
// Steps each item through capture, memory read and execute.
// ----------------------------------------------------------------------------
module ghp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output ghp_pkg::cmd_type   cmd
);

   ghp_pkg::state_type state_ff;
   ghp_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ghp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ghp_pkg::ST_IDLE: begin
            if (start) begin
               state_in = ghp_pkg::ST_READ;
            end
         end
         ghp_pkg::ST_READ: begin
            state_in = ghp_pkg::ST_EXEC;
         end
         ghp_pkg::ST_EXEC: begin
            state_in = ghp_pkg::ST_IDLE;
         end
         default: begin
            state_in = ghp_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs to the datapath and the requester.
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ghp_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ghp_pkg::ST_READ: begin
            cmd.read = 1'b1;
         end
         ghp_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

[sv/ghp_free_find.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle pool free-slot finder
// Two-level search for the lowest free slot, with the group level registered.
// ----------------------------------------------------------------------------
module ghp_free_find (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ghp_pkg::SLOTS-1:0]   slot_valid,
   output logic                        full,
   output logic [ghp_pkg::IDX_W-1:0]   free_index
);

   logic [ghp_pkg::GROUPS-1:0]   grp_free_ff;
   logic [ghp_pkg::GROUPS-1:0]   grp_free_in;
   logic [ghp_pkg::LOW_BITS-1:0] grp_first_ff [ghp_pkg::GROUPS];
   logic [ghp_pkg::LOW_BITS-1:0] grp_first_in [ghp_pkg::GROUPS];
   logic [ghp_pkg::GRP_BITS-1:0] grp_sel;

   // Per group: is any slot free, and which is the lowest free one.
   always_comb begin
      for (int g = 0; g < ghp_pkg::GROUPS; g++) begin
         grp_free_in[g]  = ~&slot_valid[g*ghp_pkg::GROUP_SIZE +: ghp_pkg::GROUP_SIZE];
         grp_first_in[g] = '0;
         for (int i = ghp_pkg::GROUP_SIZE - 1; i >= 0; i--) begin
            if (!slot_valid[g*ghp_pkg::GROUP_SIZE + i]) begin
               grp_first_in[g] = ghp_pkg::LOW_BITS'(i);
            end
         end
      end
   end

   // Group summaries; after reset every slot is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         grp_free_ff <= '1;
         for (int g = 0; g < ghp_pkg::GROUPS; g++) begin
            grp_first_ff[g] <= '0;
         end
      end else begin
         grp_free_ff <= grp_free_in;
         for (int g = 0; g < ghp_pkg::GROUPS; g++) begin
            grp_first_ff[g] <= grp_first_in[g];
         end
      end
   end

   // Lowest group that still has a free slot.
   always_comb begin
      grp_sel = '0;
      for (int g = ghp_pkg::GROUPS - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) begin
            grp_sel = ghp_pkg::GRP_BITS'(g);
         end
      end
   end

   assign full       = ~|grp_free_ff;
   assign free_index = {grp_sel, grp_first_ff[grp_sel]};

endmodule

[sv/ghp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle pool datapath
// Slot memories, valid marks, handle check and the registered result.
// ----------------------------------------------------------------------------
module ghp_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  ghp_pkg::cmd_type             cmd,
   input  logic [ghp_pkg::OP_W-1:0]     req_operation,
   input  logic [ghp_pkg::IDX_W-1:0]    req_slot_index,
   input  logic [ghp_pkg::GEN_W-1:0]    req_generation,
   input  logic [ghp_pkg::DATA_W-1:0]   req_payload_in,
   output logic                         rsp_valid,
   output logic                         rsp_ok,
   output logic [ghp_pkg::IDX_W-1:0]    rsp_handle_index,
   output logic [ghp_pkg::GEN_W-1:0]    rsp_handle_generation,
   output logic [ghp_pkg::DATA_W-1:0]   rsp_payload_out
);

   // Captured item.
   logic [ghp_pkg::OP_W-1:0]   op_ff;
   logic [ghp_pkg::IDX_W-1:0]  idx_ff;
   logic [ghp_pkg::GEN_W-1:0]  gen_ff;
   logic [ghp_pkg::DATA_W-1:0] pay_ff;

   // Slot state: valid marks and generation-written marks in flip-flops.
   logic [ghp_pkg::SLOTS-1:0]  valid_ff;
   logic [ghp_pkg::SLOTS-1:0]  seen_ff;
   logic [ghp_pkg::GEN_W-1:0]  gen_mem [ghp_pkg::SLOTS];
   logic [ghp_pkg::DATA_W-1:0] pay_mem [ghp_pkg::SLOTS];

   // Read stage.
   logic [ghp_pkg::IDX_W-1:0]  rd_addr;
   logic [ghp_pkg::IDX_W-1:0]  addr_ff;
   logic                       full_ff;
   logic                       in_range_ff;
   logic                       valid_rd_ff;
   logic                       seen_rd_ff;
   logic [ghp_pkg::GEN_W-1:0]  gen_rd_ff;
   logic [ghp_pkg::DATA_W-1:0] pay_rd_ff;

   // Execute stage.
   logic                       full;
   logic [ghp_pkg::IDX_W-1:0]  free_index;
   logic [ghp_pkg::GEN_W-1:0]  cur_gen;
   logic [ghp_pkg::GEN_W-1:0]  new_gen;
   logic                       hit;
   logic                       set_valid;
   logic                       clr_valid;
   logic                       ok_in;
   logic [ghp_pkg::IDX_W-1:0]  rid_in;
   logic [ghp_pkg::GEN_W-1:0]  rgen_in;
   logic [ghp_pkg::DATA_W-1:0] rdata_in;

   // Result register.
   logic                       rsp_valid_ff;
   logic                       rsp_ok_ff;
   logic [ghp_pkg::IDX_W-1:0]  rsp_index_ff;
   logic [ghp_pkg::GEN_W-1:0]  rsp_gen_ff;
   logic [ghp_pkg::DATA_W-1:0] rsp_data_ff;

   ghp_free_find u_free_find (
      .clock      (clock),
      .reset      (reset),
      .slot_valid (valid_ff),
      .full       (full),
      .free_index (free_index)
   );

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         idx_ff <= req_slot_index;
         gen_ff <= req_generation;
         pay_ff <= req_payload_in;
      end
   end

   // A create works on the lowest free slot, the others on the handle's slot.
   assign rd_addr = (op_ff == ghp_pkg::OP_CREATE) ? free_index : idx_ff;

   // Slot read.
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         addr_ff     <= rd_addr;
         full_ff     <= full;
         in_range_ff <= ({1'b0, idx_ff} < (ghp_pkg::IDX_W + 1)'(ghp_pkg::SLOTS));
         valid_rd_ff <= valid_ff[rd_addr];
         seen_rd_ff  <= seen_ff[rd_addr];
         gen_rd_ff   <= gen_mem[rd_addr];
         pay_rd_ff   <= pay_mem[rd_addr];
      end
   end

   // Handle check and the update that the operation asks for.
   always_comb begin
      cur_gen   = seen_rd_ff ? gen_rd_ff : '0;
      new_gen   = cur_gen + ghp_pkg::GEN_W'(1);
      hit       = in_range_ff && valid_rd_ff && (cur_gen == gen_ff);
      set_valid = 1'b0;
      clr_valid = 1'b0;
      ok_in     = 1'b0;
      rid_in    = '0;
      rgen_in   = '0;
      rdata_in  = '0;
      case (op_ff)
         ghp_pkg::OP_GET: begin
            if (hit) begin
               ok_in    = 1'b1;
               rdata_in = pay_rd_ff;
            end
         end
         ghp_pkg::OP_CREATE: begin
            if (!full_ff) begin
               set_valid = 1'b1;
               ok_in     = 1'b1;
               rid_in    = addr_ff;
               rgen_in   = new_gen;
            end
         end
         ghp_pkg::OP_REMOVE: begin
            if (hit) begin
               clr_valid = 1'b1;
               ok_in     = 1'b1;
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   // Valid and generation-written marks.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         seen_ff  <= '0;
      end else if (cmd.exec) begin
         if (set_valid) begin
            valid_ff[addr_ff] <= 1'b1;
            seen_ff[addr_ff]  <= 1'b1;
         end else if (clr_valid) begin
            valid_ff[addr_ff] <= 1'b0;
         end
      end
   end

   // Memory writes on a successful create.
   always_ff @(posedge clock) begin
      if (cmd.exec && set_valid) begin
         gen_mem[addr_ff] <= new_gen;
         pay_mem[addr_ff] <= pay_ff;
      end
   end

   // Result register: one cycle strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ok_ff    <= ok_in;
         rsp_index_ff <= rid_in;
         rsp_gen_ff   <= rgen_in;
         rsp_data_ff  <= rdata_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_ok                = rsp_ok_ff;
   assign rsp_handle_index      = rsp_index_ff;
   assign rsp_handle_generation = rsp_gen_ff;
   assign rsp_payload_out       = rsp_data_ff;

endmodule

[sv/generational_handle_pool.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle pool
// A 256-slot table of generation-checked handles with create, get and remove.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item passes
// through capture, the synchronous read of the slot's generation and payload
// memories, and the check of the handle with the write-back of the slot. Its
// result appears on the rsp_ ports for exactly one cycle, marked by rsp_valid,
// in the cycle after the write-back; the receiver cannot hold it off, and a
// new item may be started in that same cycle; the block works on one item at
// a time. The lowest free slot for a create is found by a two-level search
// whose group level is registered between items. After reset every slot is
// free and no clearing pass is needed.
module generational_handle_pool (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ghp_pkg::OP_W-1:0]     req_operation,
   input  logic [ghp_pkg::IDX_W-1:0]    req_slot_index,
   input  logic [ghp_pkg::GEN_W-1:0]    req_generation,
   input  logic [ghp_pkg::DATA_W-1:0]   req_payload_in,
   output logic                         rsp_valid,
   output logic                         rsp_ok,
   output logic [ghp_pkg::IDX_W-1:0]    rsp_handle_index,
   output logic [ghp_pkg::GEN_W-1:0]    rsp_handle_generation,
   output logic [ghp_pkg::DATA_W-1:0]   rsp_payload_out
);

   ghp_pkg::cmd_type cmd;

   ghp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   ghp_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_operation         (req_operation),
      .req_slot_index        (req_slot_index),
      .req_generation        (req_generation),
      .req_payload_in        (req_payload_in),
      .rsp_valid             (rsp_valid),
      .rsp_ok                (rsp_ok),
      .rsp_handle_index      (rsp_handle_index),
      .rsp_handle_generation (rsp_handle_generation),
      .rsp_payload_out       (rsp_payload_out)
   );

`ifndef SYNTHESIS
   // An accepted item keeps the block busy for the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting an item");

   // A result is only shown once the block has finished the item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of an item");

   // A nonzero generation is only ever returned by a successful create.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_handle_generation != '0)) |-> rsp_ok)
      else $error("generation returned by a failed item");

   // Two results are never back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on consecutive cycles");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle pool testbench
// The stimulus runs in phases. A directed opening covers the edge cases. A
// fill phase runs the table to full and beyond. Random batches then mix
// create, get and remove with live and stale handles. Each accepted item
// updates a local copy of the table, and every result is checked, field by
// field, against the oldest expected reply.
// ----------------------------------------------------------------------------
module tb;
   import ghp_pkg::*;

   // The spare operation code has no name in the package.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 600;
   localparam int SETTLE_CYCLES  = 10;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  idx;
      logic [GEN_W-1:0]  gen;
      logic [DATA_W-1:0] data;
   } pool_cmd_type;

   typedef struct packed {
      logic              ok;
      logic [IDX_W-1:0]  idx;
      logic [GEN_W-1:0]  gen;
      logic [DATA_W-1:0] data;
   } pool_reply_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [GEN_W-1:0] gen;
   } pool_handle_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [OP_W-1:0]   req_operation = '0;
   logic [IDX_W-1:0]  req_slot_index = '0;
   logic [GEN_W-1:0]  req_generation = '0;
   logic [DATA_W-1:0] req_payload_in = '0;
   logic              rsp_valid;
   logic              rsp_ok;
   logic [IDX_W-1:0]  rsp_handle_index;
   logic [GEN_W-1:0]  rsp_handle_generation;
   logic [DATA_W-1:0] rsp_payload_out;

   // Local copy of the slot table.
   logic              slot_live [SLOTS];
   logic [GEN_W-1:0]  slot_gen  [SLOTS];
   logic [DATA_W-1:0] slot_data [SLOTS];

   pool_cmd_type   cmd_backlog[$];
   pool_reply_type replies_due[$];
   pool_cmd_type   staged_cmd;

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  mismatches     = 0;
   int  quiet_cycles   = 0;
   int  gap_left       = 0;
   int  burst_left     = 1;
   logic item_taken    = 1'b0;

   generational_handle_pool u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_operation         (req_operation),
      .req_slot_index        (req_slot_index),
      .req_generation        (req_generation),
      .req_payload_in        (req_payload_in),
      .rsp_valid             (rsp_valid),
      .rsp_ok                (rsp_ok),
      .rsp_handle_index      (rsp_handle_index),
      .rsp_handle_generation (rsp_handle_generation),
      .rsp_payload_out       (rsp_payload_out)
   );

   always #10 clock = ~clock;

   // Apply one item to the local table and return the reply it should give.
   function automatic pool_reply_type execute_on_table(input pool_cmd_type c);
      pool_reply_type r;
      logic           hit;
      r   = '0;
      hit = slot_live[c.idx] && (slot_gen[c.idx] == c.gen);
      case (c.op)
         OP_GET: begin
            if (hit) begin
               r.ok   = 1'b1;
               r.data = slot_data[c.idx];
            end
         end
         OP_CREATE: begin
            // Lowest free slot wins; the generation wraps at its width.
            for (int i = 0; i < SLOTS && !r.ok; i++) begin
               if (!slot_live[i]) begin
                  slot_gen[i]  = slot_gen[i] + 1'b1;
                  slot_data[i] = c.data;
                  slot_live[i] = 1'b1;
                  r.ok  = 1'b1;
                  r.idx = i[IDX_W-1:0];
                  r.gen = slot_gen[i];
               end
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               slot_live[c.idx] = 1'b0;
               r.ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
      $display("ERROR at %0t: %s expected %0h, got %0h", $realtime, what, want, got);
      mismatches++;
   endtask

   task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [GEN_W-1:0] gen, input logic [DATA_W-1:0] data);
      pool_cmd_type c;
      c.op   = op;
      c.idx  = idx;
      c.gen  = gen;
      c.data = data;
      cmd_backlog.insert(cmd_backlog.size(), c);
      queued_count++;
   endtask

   // Hold the sender back until every queued item has been answered.
   task automatic wait_until_drained();
      while (!(accepted_count == queued_count && replies_due.size() == 0))
         @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_payload();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Sender: presents queued items in bursts separated by idle gaps.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (cmd_backlog.size() > 0) begin
            staged_cmd = cmd_backlog.pop_front();
            start          <= 1'b1;
            req_operation  <= staged_cmd.op;
            req_slot_index <= staged_cmd.idx;
            req_generation <= staged_cmd.gen;
            req_payload_in <= staged_cmd.data;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks results, predicts accepted items and watches for a hang.
   always @(posedge clock) begin : monitor
      pool_reply_type want;
      pool_reply_type due;
      if (reset) begin
         item_taken = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               report_mismatch("result with no item outstanding, ok", 0, rsp_ok);
            end else begin
               want = replies_due.pop_front();
               if (rsp_ok !== want.ok)
                  report_mismatch("ok", want.ok, rsp_ok);
               if (rsp_handle_index !== want.idx)
                  report_mismatch("handle_index", want.idx, rsp_handle_index);
               if (rsp_handle_generation !== want.gen)
                  report_mismatch("handle_generation", want.gen, rsp_handle_generation);
               if (rsp_payload_out !== want.data)
                  report_mismatch("payload_out", want.data, rsp_payload_out);
            end
         end
         item_taken = start && !busy;
         if (item_taken) begin
            due = execute_on_table('{op: req_operation, idx: req_slot_index,
                                     gen: req_generation, data: req_payload_in});
            replies_due.insert(replies_due.size(), due);
            accepted_count++;
         end
         if (rsp_valid || item_taken)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("generational_handle_pool: mismatch");
            $finish;
         end
      end
   end

   // Stimulus, phase by phase.
   initial begin : stimulus
      pool_handle_type  live[$];
      pool_handle_type  h;
      int               create_pct;
      int               remove_pct;
      int               batch_len;
      int               random_sent;
      int               free_slots;
      int               roll;

      for (int i = 0; i < SLOTS; i++) begin
         slot_live[i] = 1'b0;
         slot_gen[i]  = '0;
         slot_data[i] = '0;
      end
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed opening: free slots, extremes, stale handles, unused code.
      queue_cmd(OP_GET,    8'd0,   16'h0000, 32'h0);
      queue_cmd(OP_REMOVE, 8'd0,   16'h0000, 32'h0);
      queue_cmd(OP_CREATE, 8'd0,   16'h0000, 32'hFFFF_FFFF);
      queue_cmd(OP_CREATE, 8'd255, 16'hFFFF, 32'h0000_0000);
      queue_cmd(OP_GET,    8'd0,   16'h0001, 32'h0);
      queue_cmd(OP_GET,    8'd1,   16'h0001, 32'hFFFF_FFFF);
      queue_cmd(OP_GET,    8'd0,   16'h0000, 32'h0);
      queue_cmd(OP_GET,    8'd0,   16'hFFFF, 32'h0);
      queue_cmd(OP_GET,    8'd255, 16'hFFFF, 32'h0);
      queue_cmd(OP_REMOVE, 8'd255, 16'h0000, 32'h0);
      queue_cmd(OP_UNUSED, 8'd255, 16'hFFFF, 32'hFFFF_FFFF);
      queue_cmd(OP_GET,    8'd0,   16'h0001, 32'h0);
      queue_cmd(OP_REMOVE, 8'd0,   16'h0001, 32'h0);
      queue_cmd(OP_REMOVE, 8'd0,   16'h0001, 32'h0);
      queue_cmd(OP_GET,    8'd0,   16'h0001, 32'h0);
      queue_cmd(OP_CREATE, 8'd7,   16'h1234, 32'hA5A5_A5A5);
      queue_cmd(OP_GET,    8'd0,   16'h0002, 32'h0);
      queue_cmd(OP_GET,    8'd0,   16'h0001, 32'h0);
      queue_cmd(OP_REMOVE, 8'd1,   16'h0001, 32'h0);
      queue_cmd(OP_CREATE, 8'd0,   16'h0000, 32'h5A5A_5A5A);
      queue_cmd(OP_UNUSED, 8'd0,   16'h0000, 32'h0);
      queue_cmd(OP_GET,    8'd1,   16'h0002, 32'h0);
      wait_until_drained();

      // Run the table to full, then ask for a few more slots than exist.
      free_slots = 0;
      for (int i = 0; i < SLOTS; i++)
         if (!slot_live[i])
            free_slots++;
      for (int i = 0; i < free_slots + 3; i++)
         queue_cmd(OP_CREATE, IDX_W'($urandom), GEN_W'($urandom), pick_payload());
      wait_until_drained();

      // Random batches; handles are drawn from the table as it stood when the
      // batch was built, so later items in a batch also meet stale handles.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         live.delete();
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) begin
               h.idx = i[IDX_W-1:0];
               h.gen = slot_gen[i];
               live.insert(live.size(), h);
            end
         end
         case ($urandom_range(0, 3))
            0:       create_pct = 10;
            1:       create_pct = 40;
            2:       create_pct = 70;
            default: create_pct = 95;
         endcase
         remove_pct = $urandom_range(0, 1) ? 30 : 70;
         batch_len  = $urandom_range(4, 40);
         for (int n = 0; n < batch_len; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               queue_cmd(OP_UNUSED, IDX_W'($urandom), GEN_W'($urandom), $urandom);
            end else if (roll < 3 + create_pct) begin
               queue_cmd(OP_CREATE, IDX_W'($urandom), GEN_W'($urandom), pick_payload());
            end else begin
               if (live.size() > 0 && $urandom_range(0, 3) != 0) begin
                  h = live[$urandom_range(0, live.size() - 1)];
               end else begin
                  h.idx = IDX_W'($urandom);
                  case ($urandom_range(0, 2))
                     0:       h.gen = slot_gen[h.idx];
                     1:       h.gen = GEN_W'(slot_gen[h.idx] +
                                             ($urandom_range(0, 1) ? 1 : -1));
                     default: h.gen = GEN_W'($urandom);
                  endcase
               end
               queue_cmd(($urandom_range(0, 99) < remove_pct) ? OP_REMOVE : OP_GET,
                         h.idx, h.gen, $urandom);
            end
         end
         random_sent += batch_len;
         wait_until_drained();
      end

      // Let any stray result show itself before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("generational_handle_pool: match");
      else
         $display("generational_handle_pool: mismatch");
      $finish;
   end

endmodule
